@@ sv/frfe_pkg.sv @@
// ============================================================================
// frfe_pkg
// shared types, codes and default sizes for the frame rotate/flip engine
// ============================================================================
package frfe_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_DIM    = 256;
    localparam int DEF_PIXEL_BITS = 32;

    // fixed port widths
    localparam int PIX_PORT_W = 32;
    localparam int CFG_DIM_W  = 9;
    localparam int CFG_MODE_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_MODE  = 2'd2;

    // orientation codes, the remaining code passes the frame through
    localparam logic [CFG_MODE_W-1:0] MODE_ROT_CW   = 2'd0;
    localparam logic [CFG_MODE_W-1:0] MODE_MIRROR_H = 2'd1;
    localparam logic [CFG_MODE_W-1:0] MODE_MIRROR_V = 2'd2;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [PIX_PORT_W-1:0] pixel_in;
    } t_cmd_item;

    typedef struct packed {
        logic [PIX_PORT_W-1:0] pixel_out;
        logic                  last_of_frame;
        logic                  not_ready;
    } t_result_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic calc;
        logic read;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_DONE
    } t_fsm_state;

endpackage

@@ sv/frfe_ctrl.sv @@
// ============================================================================
// frfe_ctrl
// sequencer for load and fetch transfers of the frame rotate/flip engine
// ============================================================================
module frfe_ctrl
    import frfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_func,
    input  logic    i_cfg_we,
    output logic    busy,
    output logic    o_result_valid,
    output t_dp_cmd o_cmd
);

    t_fsm_state r_state;
    t_fsm_state n_state;
    logic       r_cfg_hold;
    logic       accept;

    // one cycle of busy after a register write lets the frame size settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cfg_hold <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg_hold <= i_cfg_we;
        end
    end

    always_comb begin
        n_state        = r_state;
        busy           = r_cfg_hold;
        o_result_valid = 1'b0;
        o_cmd          = '0;
        accept         = 1'b0;
        unique case (r_state)
            ST_IDLE, ST_DONE: begin
                o_result_valid = (r_state == ST_DONE);
                accept         = start && !r_cfg_hold;
                o_cmd.load     = accept && (i_func == FUNC_LOAD);
                if (accept && (i_func == FUNC_FETCH)) begin
                    n_state = ST_CALC;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CALC: begin
                busy       = 1'b1;
                o_cmd.calc = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                busy       = 1'b1;
                o_cmd.read = 1'b1;
                n_state    = ST_DONE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/frfe_datapath.sv @@
// ============================================================================
// frfe_datapath
// frame store, load/readout counters and reorienting address generation
// ============================================================================
module frfe_datapath
    import frfe_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [PIX_PORT_W-1:0] i_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result_item          o_result
);

    localparam int ROW_W  = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (CNT_W > CFG_DIM_W) ? CNT_W : CFG_DIM_W;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int PROD_W = 2 * CNT_W;
    // frame side after reset, the reset size of 256 saturated to the maximum
    localparam int RST_DIM = (MAX_DIM < 256) ? MAX_DIM : 256;

    // configuration registers
    logic [CFG_DIM_W-1:0]  r_frame_width;
    logic [CFG_DIM_W-1:0]  r_frame_height;
    logic [CFG_MODE_W-1:0] r_orient_mode;

    // frame state
    logic [IDX_W-1:0]      r_load_idx;
    logic [ROW_W-1:0]      r_out_row;
    logic [ROW_W-1:0]      r_out_col;
    logic                  r_ready;
    logic [IDX_W-1:0]      r_total;

    // fetch pipeline
    logic [ADDR_W-1:0]     r_prod;
    logic [ROW_W-1:0]      r_offs;
    logic                  r_not_ready;
    logic                  r_last;
    logic [PIXEL_BITS-1:0] r_rd_data;

    logic [PIXEL_BITS-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  w_c;
    logic [CNT_W-1:0]  h_c;
    logic [PROD_W-1:0] total_full;
    logic              frame_full;
    logic              load_restart;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  wr_next;
    logic [CNT_W-1:0]  ow;
    logic [CNT_W-1:0]  oh;
    logic [ROW_W-1:0]  r_cl;
    logic [ROW_W-1:0]  c_cl;
    logic [ROW_W-1:0]  a_term;
    logic [ROW_W-1:0]  b_term;
    logic              is_last;
    logic              col_wrap;
    logic [ADDR_W-1:0] rd_addr;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [CMP_W-1:0] v_ext;
        v_ext = CMP_W'(v);
        if (v_ext == '0) begin
            return CNT_W'(1);
        end else if (v_ext > CMP_W'(MAX_DIM)) begin
            return CNT_W'(MAX_DIM);
        end else begin
            return CNT_W'(v_ext);
        end
    endfunction

    assign w_c        = clamp_dim(r_frame_width);
    assign h_c        = clamp_dim(r_frame_height);
    assign total_full = PROD_W'(w_c) * PROD_W'(h_c);
    assign frame_full = (r_load_idx >= r_total);

    // load side
    assign load_restart = r_ready || frame_full;
    assign wr_idx       = load_restart ? '0 : r_load_idx;
    assign wr_next      = wr_idx + IDX_W'(1);

    // readout side: output geometry, saturated position and source terms
    always_comb begin
        ow = (r_orient_mode == MODE_ROT_CW) ? h_c : w_c;
        oh = (r_orient_mode == MODE_ROT_CW) ? w_c : h_c;
        r_cl = (CNT_W'(r_out_row) < oh) ? r_out_row : ROW_W'(oh - CNT_W'(1));
        c_cl = (CNT_W'(r_out_col) < ow) ? r_out_col : ROW_W'(ow - CNT_W'(1));
        case (r_orient_mode)
            MODE_ROT_CW: begin
                a_term = ROW_W'(h_c - CNT_W'(1) - CNT_W'(c_cl));
                b_term = r_cl;
            end
            MODE_MIRROR_H: begin
                a_term = r_cl;
                b_term = ROW_W'(w_c - CNT_W'(1) - CNT_W'(c_cl));
            end
            MODE_MIRROR_V: begin
                a_term = ROW_W'(h_c - CNT_W'(1) - CNT_W'(r_cl));
                b_term = c_cl;
            end
            default: begin
                a_term = r_cl;
                b_term = c_cl;
            end
        endcase
        is_last  = (CNT_W'(r_cl) == oh - CNT_W'(1)) && (CNT_W'(c_cl) == ow - CNT_W'(1));
        col_wrap = (CNT_W'(c_cl) + CNT_W'(1)) >= ow;
    end

    assign rd_addr = r_prod + ADDR_W'(r_offs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DIM_W'(256);
            r_frame_height <= CFG_DIM_W'(256);
            r_orient_mode  <= MODE_ROT_CW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_ORIENT_MODE:  r_orient_mode  <= i_cfg_data[CFG_MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= IDX_W'(RST_DIM * RST_DIM);
        end else begin
            r_total <= IDX_W'(total_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_ready    <= 1'b0;
        end else if (i_cmd.load) begin
            r_load_idx <= wr_next;
            r_ready    <= (wr_next >= r_total);
            if (load_restart) begin
                r_out_row <= '0;
                r_out_col <= '0;
            end
        end else if (i_cmd.calc && (r_ready || frame_full)) begin
            if (is_last) begin
                r_load_idx <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_ready    <= 1'b0;
            end else begin
                r_ready <= 1'b1;
                if (col_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= r_cl + ROW_W'(1);
                end else begin
                    r_out_col <= c_cl + ROW_W'(1);
                    r_out_row <= r_cl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_prod      <= ADDR_W'(a_term) * ADDR_W'(w_c);
            r_offs      <= b_term;
            r_not_ready <= !(r_ready || frame_full);
            r_last      <= (r_ready || frame_full) && is_last;
        end
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[wr_idx[ADDR_W-1:0]] <= i_pixel[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        o_result.pixel_out = '0;
        if (!r_not_ready) begin
            o_result.pixel_out[PIXEL_BITS-1:0] = r_rd_data;
        end
        o_result.last_of_frame = r_last;
        o_result.not_ready     = r_not_ready;
    end

endmodule

@@ sv/frame_rotate_flip_engine.sv @@
// ============================================================================
// frame_rotate_flip_engine
// frame store that loads one frame in raster order and reads it back rotated
// 90 degrees clockwise or mirrored horizontally or vertically
// ============================================================================
// A load (func 0) writes the next pixel and busy stays low, so loads may come
// every cycle unless a register write holds busy high. A fetch (func 1) forms
// the source address in the calc state (row times width, one multiply), does
// the registered frame store read in the read state and puts the result on
// o_result with o_result_valid high in the done state; busy is high in the
// calc and read states, and a new transfer may be started in the done state.
// The result is shown for exactly one cycle and the receiver cannot hold it
// off. After any register write busy is high for one cycle while the frame
// size is recomputed. The frame store is not cleared after reset.
module frame_rotate_flip_engine
    import frfe_pkg::*;
#(
    parameter int MAX_DIM    = DEF_MAX_DIM,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command transfer
    input  logic                  start,
    output logic                  busy,
    input  t_cmd_item             i_cmd,
    // result transfer, one cycle strobe
    output logic                  o_result_valid,
    output t_result_item          o_result,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // command bundle from the sequencer into the datapath
    t_dp_cmd dp_cmd;

    frfe_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_func         (i_cmd.func),
        .i_cfg_we       (i_cfg_we),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (dp_cmd)
    );

    // frame store, counters and address generation
    frfe_datapath #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_pixel    (i_cmd.pixel_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the frame rotate/flip engine
// loads frames in raster order, fetches them back and checks each pixel and
// flag against a shadow frame store that follows every accepted transfer
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frfe_pkg::*;

    // the pass-through orientation has no code of its own in the package
    localparam logic [CFG_MODE_W-1:0] MODE_PASS = 2'd3;

    // quiet cycles tolerated before the run is declared hung
    localparam int QUIET_LIMIT   = 500;
    // idle cycles allowed for loads still in flight before a register write
    localparam int SETTLE_CYCLES = 6;
    // random part only; the directed and full-size frames add about 1000 more
    localparam int RANDOM_ITEMS  = 200;
    localparam int STORE_DEPTH   = DEF_MAX_DIM * DEF_MAX_DIM;

    // ------------------------------------------------------------------------
    // shadow frame store and queue of pixels still owed by the block
    // ------------------------------------------------------------------------
    class frame_order_board;
        bit [PIX_PORT_W-1:0] shadow_store [STORE_DEPTH];
        bit                  shadow_written [STORE_DEPTH];
        logic [16:0]         load_idx;
        logic [7:0]          row_pos;
        logic [7:0]          col_pos;
        bit                  ready;
        logic [CFG_DIM_W-1:0]  reg_width;
        logic [CFG_DIM_W-1:0]  reg_height;
        logic [CFG_MODE_W-1:0] reg_mode;
        t_result_item        expected_pixels [$];
        int                  errors;
        int                  loads_seen;
        int                  fetches_seen;
        int                  not_ready_seen;
        int                  frames_out;

        function new();
            restart();
            reg_width  = 9'd256;
            reg_height = 9'd256;
            reg_mode   = MODE_ROT_CW;
            errors = 0;
            loads_seen = 0;
            fetches_seen = 0;
            not_ready_seen = 0;
            frames_out = 0;
        endfunction

        function void restart();
            load_idx = '0;
            row_pos  = '0;
            col_pos  = '0;
            ready    = 1'b0;
        endfunction

        // zero behaves as one, anything above the maximum saturates
        function int unsigned eff_dim(logic [CFG_DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
            return v;
        endfunction

        function int unsigned frame_pixels();
            return eff_dim(reg_width) * eff_dim(reg_height);
        endfunction

        // frame complete or being read out
        function bit readout_pending();
            return ready || (load_idx >= frame_pixels());
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH:  reg_width  = data;
                CFG_FRAME_HEIGHT: reg_height = data;
                CFG_ORIENT_MODE:  reg_mode   = data[CFG_MODE_W-1:0];
                default: ;
            endcase
        endfunction

        // source address of the next output pixel; 0 when nothing is readable
        function bit locate(output int unsigned src, output bit is_last,
                            output int unsigned nxt_row, output int unsigned nxt_col);
            int unsigned w, h, ow, oh, r, c;
            w = eff_dim(reg_width);
            h = eff_dim(reg_height);
            src = 0;
            is_last = 1'b0;
            nxt_row = 0;
            nxt_col = 0;
            if (!(ready || load_idx >= w * h)) return 1'b0;
            r = ready ? row_pos : 0;
            c = ready ? col_pos : 0;
            ow = (reg_mode == MODE_ROT_CW) ? h : w;
            oh = (reg_mode == MODE_ROT_CW) ? w : h;
            // position left beyond a shrunk output saturates
            if (r >= oh) r = oh - 1;
            if (c >= ow) c = ow - 1;
            case (reg_mode)
                MODE_ROT_CW:   src = (h - 1 - c) * w + r;
                MODE_MIRROR_H: src = r * w + (w - 1 - c);
                MODE_MIRROR_V: src = (h - 1 - r) * w + c;
                default:       src = r * w + c;
            endcase
            src = src % STORE_DEPTH;
            is_last = (r == oh - 1) && (c == ow - 1);
            if (c + 1 >= ow) begin
                nxt_col = 0;
                nxt_row = r + 1;
            end else begin
                nxt_col = c + 1;
                nxt_row = r;
            end
            return 1'b1;
        endfunction

        // a fetch now must not read an entry that was never loaded
        function bit fetch_is_safe();
            int unsigned src, nr, nc;
            bit last;
            if (!locate(src, last, nr, nc)) return 1'b1;
            return shadow_written[src];
        endfunction

        function void note_transfer(t_cmd_item item);
            int unsigned total, src, nr, nc;
            bit last;
            t_result_item res;
            total = frame_pixels();
            if (item.func == FUNC_LOAD) begin
                // a load after completion or during readout opens a new frame
                if (ready || load_idx >= total) restart();
                shadow_store[load_idx[15:0]]   = item.pixel_in;
                shadow_written[load_idx[15:0]] = 1'b1;
                load_idx = load_idx + 1'b1;
                if (load_idx >= total) ready = 1'b1;
                loads_seen++;
            end else begin
                fetches_seen++;
                // frame completed by shrinking the size while loading
                if (!ready && load_idx >= total) begin
                    ready   = 1'b1;
                    row_pos = '0;
                    col_pos = '0;
                end
                if (!locate(src, last, nr, nc)) begin
                    res.pixel_out     = '0;
                    res.last_of_frame = 1'b0;
                    res.not_ready     = 1'b1;
                    not_ready_seen++;
                end else begin
                    res.pixel_out     = shadow_store[src];
                    res.last_of_frame = last;
                    res.not_ready     = 1'b0;
                    if (last) begin
                        restart();
                        frames_out++;
                    end else begin
                        row_pos = nr[7:0];
                        col_pos = nc[7:0];
                    end
                end
                expected_pixels.push_back(res);
            end
        endfunction

        function void check_pixel(t_result_item got);
            t_result_item want;
            if (expected_pixels.size() == 0) begin
                $error("result with nothing expected: pixel_out %h", got.pixel_out);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out) begin
                $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
                errors++;
            end
            if (got.last_of_frame !== want.last_of_frame) begin
                $error("last_of_frame: expected %b, got %b",
                       want.last_of_frame, got.last_of_frame);
                errors++;
            end
            if (got.not_ready !== want.not_ready) begin
                $error("not_ready: expected %b, got %b", want.not_ready, got.not_ready);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, stimulus signals and the block
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_cmd_item             i_cmd = '0;
    logic                  o_result_valid;
    t_result_item          o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    frame_order_board sb = new();

    bit start_high = 1'b0;
    int items_sent = 0;
    int cfg_writes = 0;
    int burst_left = 0;

    initial forever #2 i_clk = ~i_clk;

    frame_rotate_flip_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // results cannot be held off, so every strobe is checked at its edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) sb.check_pixel(o_result);
    end

    // hang detector: any cycle with a transfer or a result resets the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_result_valid) quiet = 0;
            else quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // start stays high on return so the next transfer can follow back to back
    task automatic send_item(input logic func, input logic [PIX_PORT_W-1:0] pix);
        t_cmd_item item;
        item.func     = func;
        item.pixel_in = pix;
        start    <= 1'b1;
        i_cmd    <= item;
        start_high = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_transfer(item);
        items_sent++;
    endtask

    task automatic drop_start();
        if (start_high) begin
            start <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    // sender bursts: random length, random gaps, some long gap-free stretches
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            drop_start();
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // wait for all owed pixels, then let trailing loads drain
    task automatic settle();
        drop_start();
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // back-to-back register writes; only valid while the block is idle
    task automatic write_regs(input bit wr_w, input bit wr_h, input bit wr_m,
                              input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] m);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        bit                    en [3];
        bit                    any;
        idx[0] = CFG_FRAME_WIDTH;
        idx[1] = CFG_FRAME_HEIGHT;
        idx[2] = CFG_ORIENT_MODE;
        val[0] = w;
        val[1] = h;
        val[2] = m;
        en[0]  = wr_w;
        en[1]  = wr_h;
        en[2]  = wr_m;
        any    = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (en[k]) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= idx[k];
                i_cfg_data <= val[k];
                @(posedge i_clk);
                sb.note_config(idx[k], val[k]);
                cfg_writes++;
                any = 1'b1;
            end
        end
        if (any) i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_PORT_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // mostly tiny frames, a few medium ones, now and then a zero size
    function automatic logic [CFG_DATA_W-1:0] rand_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 9'($urandom_range(7, 17));
            default: return 9'($urandom_range(1, 6));
        endcase
    endfunction

    // upper data bits are ignored by the mode register
    function automatic logic [CFG_DATA_W-1:0] rand_mode_data();
        logic [CFG_DATA_W-1:0] d;
        d = '0;
        if ($urandom_range(0, 3) == 0) d = 9'($urandom);
        d[CFG_MODE_W-1:0] = ($urandom_range(0, 5) == 0) ? MODE_PASS
                                                        : 2'($urandom_range(0, 2));
        return d;
    endfunction

    // fetch until the frame rearms, without pacing
    task automatic read_out();
        while (sb.readout_pending() && sb.fetch_is_safe())
            send_item(FUNC_FETCH, $urandom);
    endtask

    // size or orientation change in the middle of a readout
    task automatic reshape_mid_readout();
        int unsigned w, h;
        w = sb.eff_dim(sb.reg_width);
        h = sb.eff_dim(sb.reg_height);
        settle();
        case ($urandom_range(0, 2))
            0: write_regs(1'b0, 1'b0, 1'b1, '0, '0, rand_mode_data());
            1: write_regs(1'b1, 1'b1, 1'b0, 9'($urandom_range(1, w)),
                          9'($urandom_range(1, h)), '0);
            default: write_regs(1'b1, 1'b1, 1'b1, rand_dim(), rand_dim(),
                                rand_mode_data());
        endcase
    endtask

    // one frame: loading with optional early fetches, then readout that may be
    // cut by a restarting load or interrupted by a register change
    task automatic run_frame();
        int  total, n, cut_at, reshape_at;
        bit  noisy;
        total      = sb.frame_pixels();
        noisy      = ($urandom_range(0, 4) == 0);
        cut_at     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total) : -1;
        reshape_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total) : -1;
        while (!sb.readout_pending()) begin
            if (noisy && $urandom_range(0, 3) == 0) send_item(FUNC_FETCH, $urandom);
            else send_item(FUNC_LOAD, rand_pixel());
            pace();
        end
        n = 0;
        while (sb.readout_pending()) begin
            if (n == cut_at) begin
                send_item(FUNC_LOAD, rand_pixel());
                pace();
                break;
            end
            if (n == reshape_at) reshape_mid_readout();
            if (!sb.fetch_is_safe()) begin
                send_item(FUNC_LOAD, rand_pixel());
                pace();
                break;
            end
            send_item(FUNC_FETCH, $urandom);
            pace();
            n++;
        end
        // stray fetch after the frame, normally answered as not ready
        if ($urandom_range(0, 9) == 0 && sb.fetch_is_safe()) begin
            send_item(FUNC_FETCH, $urandom);
            pace();
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] w,
                             input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] m, input int frames);
        settle();
        write_regs(1'b1, 1'b1, 1'b1, w, h, m);
        repeat (frames) run_frame();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        int base;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fetch straight after reset, then a partial frame
        send_item(FUNC_FETCH, '1);
        send_item(FUNC_LOAD, '0);
        send_item(FUNC_LOAD, '1);
        send_item(FUNC_LOAD, 32'hA5A5_A5A5);
        send_item(FUNC_FETCH, '0);

        // shrinking the size below what was loaded completes the frame
        settle();
        write_regs(1'b1, 1'b1, 1'b0, 9'd1, 9'd2, '0);
        read_out();

        // mirror, cut short by a load during readout
        settle();
        write_regs(1'b1, 1'b1, 1'b1, 9'd3, 9'd2, 9'(MODE_MIRROR_H));
        repeat (6) send_item(FUNC_LOAD, rand_pixel());
        repeat (3) send_item(FUNC_FETCH, $urandom);
        send_item(FUNC_LOAD, 32'h5A5A_5A5A);
        while (!sb.readout_pending()) send_item(FUNC_LOAD, rand_pixel());

        // orientation switched to pass-through halfway through the readout
        repeat (2) send_item(FUNC_FETCH, $urandom);
        settle();
        write_regs(1'b0, 1'b0, 1'b1, '0, '0, 9'(MODE_PASS));
        read_out();

        // extreme sizes: one row of full width, one column of full height
        run_phase(9'd256, 9'd0, 9'(MODE_ROT_CW), 1);
        run_phase(9'd0, 9'd511, 9'(MODE_MIRROR_V), 1);

        // random frames
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
            run_phase(rand_dim(), rand_dim(), rand_mode_data(), $urandom_range(1, 3));

        settle();
        $display("run: %0d loads, %0d fetches (%0d not ready), %0d frames read out",
                 sb.loads_seen, sb.fetches_seen, sb.not_ready_seen, sb.frames_out);
        $display("run: %0d register writes, %0d mismatches", cfg_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
